>>> design/gcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcs_pkg;

    // Widths of the vertex, command and size fields on the ports.
    localparam int VERTEX_W = 6;
    localparam int OP_W     = 2;
    localparam int SIZE_W   = 7;

    // Command codes carried on the op port.
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH   = 2'd2;

    // Control from the sequencer to the pruning unit.
    typedef struct packed {
        logic                load;  // Start a new neighbor set from the fetched row.
        logic [VERTEX_W-1:0] idx;   // Neighbor index whose row is presented.
    } prune_cmd_t;

endpackage

`default_nettype wire

>>> design/gcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

>>> design/gcs_prune.sv
`timescale 1ns / 1ps
`default_nettype none

module gcs_prune #(
    parameter int ROW_W = 64
) (
    input  wire logic [ROW_W-1:0]      kept,
    input  wire logic [ROW_W-1:0]      row,
    input  wire logic [ROW_W-1:0]      range_mask,
    input  wire gcs_pkg::prune_cmd_t   cmd,
    output logic      [ROW_W-1:0]      kept_next,
    output logic                       hit
);

    import gcs_pkg::*;

    localparam int IDX_W = $clog2(ROW_W);

    // A load keeps the row in range; else a kept neighbor drops later non-neighbors.
    always_comb
    begin
        hit = 1'b0;
        if (cmd.load)
        begin
            kept_next = row & range_mask;
        end
        else
        begin
            hit = kept[cmd.idx[IDX_W-1:0]];
            for (int k = 0; k < ROW_W; k++)
            begin
                kept_next[k] = kept[k] & (!hit || (VERTEX_W'(k) <= cmd.idx) || row[k]);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/greedy_clique_search_core.sv
// Busy does not rise for a clear or an out-of-range edge; an edge insert holds it high through
// two read-modify-writes of the endpoint rows, and a search through a pass over each center up
// to top = min(vertex_count, MAX_VERTICES-1), then the member stream. Each result strobe shows
// in the cycle after the sequencer step that produces it.
// One command at a time; the next is taken at the first edge with busy low.
// Reset (rst_n, asynchronous, active low) clears the graph and vertex_count; results never stall.
`timescale 1ns / 1ps
`default_nettype none

module greedy_clique_search_core #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Command transaction.
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [gcs_pkg::OP_W-1:0]      op,
    input  wire logic [gcs_pkg::VERTEX_W-1:0]  vertex_a,
    input  wire logic [gcs_pkg::VERTEX_W-1:0]  vertex_b,
    // Configuration transaction: the vertex_count register.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gcs_pkg::VERTEX_W-1:0]  cfg_data,
    // Result transactions.
    output logic                               result_valid,
    output logic [gcs_pkg::SIZE_W-1:0]         clique_size,
    output logic [gcs_pkg::VERTEX_W-1:0]       center_vertex,
    output logic [gcs_pkg::VERTEX_W-1:0]       member_vertex,
    output logic                               member_valid,
    output logic                               last
);

    import gcs_pkg::*;

    localparam int N     = MAX_VERTICES;
    localparam int IDX_W = $clog2(N);
    // Sizes reach N+1 when a self-loop makes the center its own member.
    localparam int SZ_W  = $clog2(N + 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_RD_A,
        S_EDGE_WR_A,
        S_EDGE_RD_B,
        S_EDGE_WR_B,
        S_SRCH_RD_V,
        S_SRCH_LOAD,
        S_SRCH_STEP,
        S_SRCH_CMP,
        S_EMIT_START,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    // The adjacency matrix lives in a RAM with one row per vertex. A row whose valid
    // bit is clear reads as all zero, so a clear command only has to drop the valid bits.
    logic [N-1:0]        row_valid_reg, row_valid_next;
    logic                rd_valid_reg;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [N-1:0]        ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [N-1:0]        ram_rdata;
    logic [N-1:0]        row_data;

    logic [VERTEX_W-1:0] vertex_count_reg, vertex_count_next;

    // Edge endpoints held across the read-modify-write sequence.
    logic [IDX_W-1:0]    a_reg, a_next;
    logic [IDX_W-1:0]    b_reg, b_next;

    // Search state: center vertex v, neighbor index i, survivor set and its count.
    logic [IDX_W-1:0]    top_reg, top_next;
    logic [N-1:0]        range_reg, range_next;
    logic [IDX_W-1:0]    v_reg, v_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [N-1:0]        kept_reg, kept_next;
    logic [SZ_W-1:0]     count_reg, count_next;
    logic [SZ_W-1:0]     best_size_reg, best_size_next;
    logic [IDX_W-1:0]    best_center_reg, best_center_next;
    logic [N-1:0]        best_members_reg, best_members_next;
    logic [SZ_W-1:0]     cand_size;

    // Result streaming: remaining members shifted down, with the index of bit zero.
    logic [N-1:0]        rest_reg, rest_next;
    logic [IDX_W-1:0]    j_reg, j_next;

    // Registered result ports.
    logic                result_valid_reg, result_valid_next;
    logic [SIZE_W-1:0]   clique_size_reg, clique_size_next;
    logic [VERTEX_W-1:0] center_vertex_reg, center_vertex_next;
    logic [VERTEX_W-1:0] member_vertex_reg, member_vertex_next;
    logic                member_valid_reg, member_valid_next;
    logic                last_reg, last_next;

    logic [IDX_W-1:0]    top_sat;
    logic                a_in_range;
    logic                b_in_range;

    prune_cmd_t          prune_cmd;
    logic [N-1:0]        prune_kept;
    logic                prune_hit;

    gcs_ram #(
        .WIDTH (N),
        .DEPTH (N)
    ) u_adj_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The shared pruning unit: one neighbor row is applied per cycle.
    gcs_prune #(
        .ROW_W (N)
    ) u_prune (
        .kept       (kept_reg),
        .row        (row_data),
        .range_mask (range_reg),
        .cmd        (prune_cmd),
        .kept_next  (prune_kept),
        .hit        (prune_hit)
    );

    assign row_data  = rd_valid_reg ? ram_rdata : '0;
    assign cand_size = count_reg + SZ_W'(1);

    // The configured count is clamped to the highest vertex the matrix holds.
    assign top_sat = (vertex_count_reg >= VERTEX_W'(N - 1)) ? IDX_W'(N - 1)
                                                            : vertex_count_reg[IDX_W-1:0];

    // Edges that name a vertex beyond the matrix are dropped.
    assign a_in_range = ({1'b0, vertex_a} < (VERTEX_W + 1)'(N));
    assign b_in_range = ({1'b0, vertex_b} < (VERTEX_W + 1)'(N));

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_valid  = result_valid_reg;
    assign clique_size   = clique_size_reg;
    assign center_vertex = center_vertex_reg;
    assign member_vertex = member_vertex_reg;
    assign member_valid  = member_valid_reg;
    assign last          = last_reg;

    always_comb
    begin
        state_next         = state_reg;
        row_valid_next     = row_valid_reg;
        vertex_count_next  = vertex_count_reg;
        a_next             = a_reg;
        b_next             = b_reg;
        top_next           = top_reg;
        range_next         = range_reg;
        v_next             = v_reg;
        i_next             = i_reg;
        kept_next          = kept_reg;
        count_next         = count_reg;
        best_size_next     = best_size_reg;
        best_center_next   = best_center_reg;
        best_members_next  = best_members_reg;
        rest_next          = rest_reg;
        j_next             = j_reg;
        result_valid_next  = 1'b0;
        clique_size_next   = clique_size_reg;
        center_vertex_next = center_vertex_reg;
        member_vertex_next = member_vertex_reg;
        member_valid_next  = member_valid_reg;
        last_next          = last_reg;
        ram_we             = 1'b0;
        ram_waddr          = a_reg;
        ram_wdata          = row_data | (N'(1) << b_reg);
        ram_raddr          = v_reg;
        prune_cmd.load     = 1'b0;
        prune_cmd.idx      = VERTEX_W'(i_reg);

        // The register may be written at any time; a search latches its range when it starts.
        if (cfg_valid)
        begin
            vertex_count_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        OP_ADD_EDGE:
                        begin
                            if (a_in_range && b_in_range)
                            begin
                                a_next     = vertex_a[IDX_W-1:0];
                                b_next     = vertex_b[IDX_W-1:0];
                                state_next = S_EDGE_RD_A;
                            end
                        end
                        OP_SEARCH:
                        begin
                            top_next = top_sat;
                            for (int k = 0; k < N; k++)
                            begin
                                range_next[k] = (IDX_W'(k) <= top_sat);
                            end
                            v_next            = '0;
                            best_size_next    = '0;
                            best_center_next  = '0;
                            best_members_next = '0;
                            state_next        = S_SRCH_RD_V;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Each endpoint's row is read, the other endpoint's bit is set, and it is written back.
            S_EDGE_RD_A:
            begin
                ram_raddr  = a_reg;
                state_next = S_EDGE_WR_A;
            end

            S_EDGE_WR_A:
            begin
                ram_we                = 1'b1;
                ram_waddr             = a_reg;
                ram_wdata             = row_data | (N'(1) << b_reg);
                row_valid_next[a_reg] = 1'b1;
                state_next            = S_EDGE_RD_B;
            end

            S_EDGE_RD_B:
            begin
                ram_raddr  = b_reg;
                state_next = S_EDGE_WR_B;
            end

            S_EDGE_WR_B:
            begin
                ram_we                = 1'b1;
                ram_waddr             = b_reg;
                ram_wdata             = row_data | (N'(1) << a_reg);
                row_valid_next[b_reg] = 1'b1;
                state_next            = S_IDLE;
            end

            S_SRCH_RD_V:
            begin
                ram_raddr  = v_reg;
                state_next = S_SRCH_LOAD;
            end

            // The center's row arrives and seeds the survivor set; the first neighbor row is fetched.
            S_SRCH_LOAD:
            begin
                prune_cmd.load = 1'b1;
                kept_next      = prune_kept;
                count_next     = '0;
                i_next         = '0;
                ram_raddr      = '0;
                state_next     = S_SRCH_STEP;
            end

            // Row i is applied while row i+1 is fetched. Bit i cannot change after its own
            // step, so a kept bit here is a final survivor and is counted at once.
            S_SRCH_STEP:
            begin
                kept_next  = prune_kept;
                count_next = count_reg + SZ_W'(prune_hit);
                if (i_reg == top_reg)
                begin
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    i_next    = i_reg + 1'b1;
                    ram_raddr = i_reg + 1'b1;
                end
            end

            // A strictly larger clique replaces the best one; the next center's row is fetched.
            S_SRCH_CMP:
            begin
                if (cand_size > best_size_reg)
                begin
                    best_size_next    = cand_size;
                    best_center_next  = v_reg;
                    best_members_next = kept_reg;
                end
                if (v_reg == top_reg)
                begin
                    state_next = S_EMIT_START;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    ram_raddr  = v_reg + 1'b1;
                    state_next = S_SRCH_LOAD;
                end
            end

            S_EMIT_START:
            begin
                rest_next = best_members_reg;
                j_next    = '0;
                if (best_members_reg == '0)
                begin
                    // A clique of the center alone gives one result with no member.
                    result_valid_next  = 1'b1;
                    clique_size_next   = SIZE_W'(best_size_reg);
                    center_vertex_next = VERTEX_W'(best_center_reg);
                    member_vertex_next = '0;
                    member_valid_next  = 1'b0;
                    last_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            // Members go out in ascending order, one bit position per cycle.
            S_EMIT:
            begin
                rest_next = rest_reg >> 1;
                j_next    = j_reg + 1'b1;
                if (rest_reg[0])
                begin
                    result_valid_next  = 1'b1;
                    clique_size_next   = SIZE_W'(best_size_reg);
                    center_vertex_next = VERTEX_W'(best_center_reg);
                    member_vertex_next = VERTEX_W'(j_reg);
                    member_valid_next  = 1'b1;
                    last_next          = (rest_reg[N-1:1] == '0);
                    if (rest_reg[N-1:1] == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            row_valid_reg     <= '0;
            rd_valid_reg      <= 1'b0;
            vertex_count_reg  <= '0;
            a_reg             <= '0;
            b_reg             <= '0;
            top_reg           <= '0;
            range_reg         <= '0;
            v_reg             <= '0;
            i_reg             <= '0;
            kept_reg          <= '0;
            count_reg         <= '0;
            best_size_reg     <= '0;
            best_center_reg   <= '0;
            best_members_reg  <= '0;
            rest_reg          <= '0;
            j_reg             <= '0;
            result_valid_reg  <= 1'b0;
            clique_size_reg   <= '0;
            center_vertex_reg <= '0;
            member_vertex_reg <= '0;
            member_valid_reg  <= 1'b0;
            last_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            row_valid_reg     <= row_valid_next;
            rd_valid_reg      <= row_valid_reg[ram_raddr];
            vertex_count_reg  <= vertex_count_next;
            a_reg             <= a_next;
            b_reg             <= b_next;
            top_reg           <= top_next;
            range_reg         <= range_next;
            v_reg             <= v_next;
            i_reg             <= i_next;
            kept_reg          <= kept_next;
            count_reg         <= count_next;
            best_size_reg     <= best_size_next;
            best_center_reg   <= best_center_next;
            best_members_reg  <= best_members_next;
            rest_reg          <= rest_next;
            j_reg             <= j_next;
            result_valid_reg  <= result_valid_next;
            clique_size_reg   <= clique_size_next;
            center_vertex_reg <= center_vertex_next;
            member_vertex_reg <= member_vertex_next;
            member_valid_reg  <= member_valid_next;
            last_reg          <= last_next;
        end
    end

endmodule

`default_nettype wire
